FILE: hw/rtl/postfix_stack_evaluator_macros.svh
// Assertion macros shared by the postfix evaluator RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// Checked on every clock edge outside reset.
`define PSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define PSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/psev_pkg.sv
// Shared constants, token and status codes and divider interface types.
// Used by every module of the postfix evaluator except psev_ram.
package psev_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic [2:0] CMD_NUM = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_SUB = 3'd2;
  localparam logic [2:0] CMD_MUL = 3'd3;
  localparam logic [2:0] CMD_DIV = 3'd4;
  localparam logic [2:0] CMD_END = 3'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FEW    = 3'd1;
  localparam logic [2:0] ST_DIV0   = 3'd2;
  localparam logic [2:0] ST_BAD    = 3'd3;
  localparam logic [2:0] ST_NOTONE = 3'd4;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } psev_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } psev_div_rsp_t;

endpackage

FILE: hw/rtl/postfix_stack_evaluator.sv
// Top level of the postfix evaluator: token sequencer, operand stack RAM, divider.
// Depends on psev_pkg, psev_ram, psev_div and postfix_stack_evaluator_macros.svh.
`include "postfix_stack_evaluator_macros.svh"

// Evaluates postfix expressions one token per input transaction and returns exactly one
// result transaction per token. Number, invalid and ignored tokens, and an end token that
// reports an error, are answered straight from the idle state. An end token that reports
// a value first reads the bottom stack entry. Add, subtract and multiply read the top and
// next operands one after the other through the single read port of the stack RAM, and
// then write the result back. Divide runs the radix-2 divider, which retires one quotient
// bit per cycle; a divide by zero ends after the operand reads. The stack store needs no
// clearing after reset, since only entries below the fill count are read.
// A new token is taken while the previous result leaves the output register.
module postfix_stack_evaluator
  import psev_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] operand_value, [31] zero fill
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast   // done_res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_N   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_END_RD = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [2:0]        err_r, err_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [DATA_W-1:0] t_r, t_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  psev_div_req_t     div_req;
  psev_div_rsp_t     div_rsp;

  logic              in_accept;
  logic [ADDR_W-1:0] top_idx;
  logic [ADDR_W-1:0] next_idx;
  logic [DATA_W-1:0] alu_res;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;

  assign top_idx  = ADDR_W'(count_r - CNT_W'(1));
  assign next_idx = ADDR_W'(count_r - CNT_W'(2));

  always_comb begin
    case (cmd_r)
      CMD_ADD: alu_res = mem_rdata + t_r;
      CMD_SUB: alu_res = mem_rdata - t_r;
      default: alu_res = mem_rdata * t_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    cmd_nxt        = cmd_r;
    t_nxt          = t_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[ADDR_W-1:0];
    mem_wdata      = {1'b0, in_tdata[30:0]};
    mem_raddr      = top_idx;
    div_req.start    = 1'b0;
    div_req.dividend = mem_rdata;
    div_req.divisor  = t_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt        = in_tuser;
          out_data_nxt   = '0;
          out_last_nxt   = 1'b0;
          out_status_nxt = err_r;
          if (in_tuser == CMD_END) begin
            count_nxt    = '0;
            err_nxt      = ST_OK;
            out_last_nxt = 1'b0;
            if (err_r != ST_OK) begin
              out_valid_nxt  = 1'b1;
              out_data_nxt   = '1;
              out_last_nxt   = 1'b1;
            end else if (count_r != CNT_W'(1)) begin
              out_valid_nxt  = 1'b1;
              out_data_nxt   = '1;
              out_status_nxt = ST_NOTONE;
              out_last_nxt   = 1'b1;
            end else begin
              mem_raddr = '0;
              state_nxt = S_END_RD;
            end
          end else if (err_r != ST_OK) begin
            out_valid_nxt = 1'b1;
          end else begin
            unique case (in_tuser) inside
              CMD_NUM: begin
                // A push onto a full stack is dropped without an error.
                if (count_r < CNT_W'(STACK_DEPTH)) begin
                  mem_we    = 1'b1;
                  count_nxt = count_r + CNT_W'(1);
                end
                out_valid_nxt = 1'b1;
              end
              [CMD_ADD:CMD_DIV]: begin
                if (count_r < CNT_W'(2)) begin
                  err_nxt        = ST_FEW;
                  out_status_nxt = ST_FEW;
                  out_valid_nxt  = 1'b1;
                end else begin
                  state_nxt = S_RD_N;
                end
              end
              default: begin
                err_nxt        = ST_BAD;
                out_status_nxt = ST_BAD;
                out_valid_nxt  = 1'b1;
              end
            endcase
          end
        end
      end
      S_RD_N: begin
        t_nxt     = mem_rdata;
        mem_raddr = next_idx;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        out_data_nxt = '0;
        out_last_nxt = 1'b0;
        if (cmd_r == CMD_DIV) begin
          if (t_r == '0) begin
            // Both operands are consumed and nothing is pushed.
            count_nxt      = count_r - CNT_W'(2);
            err_nxt        = ST_DIV0;
            out_status_nxt = ST_DIV0;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = next_idx;
          mem_wdata      = alu_res;
          count_nxt      = count_r - CNT_W'(1);
          out_status_nxt = ST_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          mem_we         = 1'b1;
          mem_waddr      = next_idx;
          mem_wdata      = div_rsp.quotient;
          count_nxt      = count_r - CNT_W'(1);
          out_status_nxt = ST_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_END_RD: begin
        out_data_nxt   = mem_rdata;
        out_status_nxt = ST_OK;
        out_last_nxt   = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    t_r          <= t_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  psev_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  psev_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  `PSE_ASSERT(a_count_bound, count_r <= CNT_W'(STACK_DEPTH), "stack fill count above depth")
  `PSE_ASSERT(a_end_clears, (out_valid_r && out_last_r) |-> (count_r == '0 && err_r == ST_OK), "stack or error not cleared after end")
  `PSE_ASSERT(a_err_ignores, (in_accept && err_r != ST_OK) |=> (state_r == S_IDLE), "token after an error started stack work")
  `PSE_ASSERT(a_div_nonzero, div_req.start |-> (div_req.divisor != '0 && state_r == S_EXEC), "divider started on a zero divisor")
  `PSE_ASSERT_ALWAYS(a_busy_no_ready, (state_r != S_IDLE) |-> !in_tready, "token taken while a token is in progress")

endmodule

FILE: hw/rtl/psev_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module psev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/psev_div.sv
// Radix-2 restoring divider for signed 32-bit truncating division.
// Depends on psev_pkg for the request and response types.
module psev_div
  import psev_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  psev_div_req_t req,
  output psev_div_rsp_t rsp
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [4:0]          step_r, step_nxt;
  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   quo_r, quo_nxt;
  logic [DATA_W-1:0]   den_r, den_nxt;
  logic                neg_r, neg_nxt;
  logic [DATA_W:0]     trial;

  assign trial = {rem_r, quo_r[DATA_W-1]} - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          quo_nxt   = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
          den_nxt   = req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
          neg_nxt   = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        // A non-negative trial difference means the shifted remainder holds the divisor.
        if (!trial[DATA_W]) begin
          rem_nxt = trial[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          state_nxt = D_FIN;
        end
      end
      D_FIN: begin
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
  end

  assign rsp.done     = (state_r == D_FIN);
  assign rsp.quotient = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

endmodule

FILE: sim/postfix_stack_evaluator_checker.sv
// Stream checker for postfix_stack_evaluator: it watches the token and result streams,
// predicts every result from the accepted tokens and compares field by field.
// Depends on psev_pkg for the stack depth and the token and status codes.
module postfix_stack_evaluator_checker
  import psev_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
    logic        closes;
  } token_result_t;

  token_result_t pending_results[$];
  logic [31:0]   operand_stack[STACK_DEPTH];
  int unsigned   stack_fill;
  logic [2:0]    held_error;
  int            fail_count = 0;
  int            waiting = 0;

  assign mismatches  = fail_count;
  assign outstanding = waiting;

  // Signed division that truncates toward zero; the most negative value over -1 wraps.
  function automatic logic [31:0] trunc_divide(logic [31:0] dividend, logic [31:0] divisor);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] quot;
    mag_n = dividend[31] ? -dividend : dividend;
    mag_d = divisor[31] ? -divisor : divisor;
    quot  = mag_n / mag_d;
    return (dividend[31] ^ divisor[31]) ? -quot : quot;
  endfunction

  function automatic token_result_t evaluate_token(logic [2:0] cmd, logic [30:0] operand);
    token_result_t res;
    logic [31:0]   top;
    logic [31:0]   nxt;
    logic [31:0]   acc;
    res.value  = '0;
    res.status = ST_OK;
    res.closes = 1'b0;
    if (cmd == CMD_END) begin
      res.closes = 1'b1;
      if (held_error != ST_OK) begin
        res.value  = '1;
        res.status = held_error;
      end else if (stack_fill != 1) begin
        res.value  = '1;
        res.status = ST_NOTONE;
      end else begin
        res.value = operand_stack[0];
      end
      stack_fill = 0;
      held_error = ST_OK;
    end else begin
      // Once an error is latched, everything but an end token is ignored.
      if (held_error == ST_OK) begin
        if (cmd == CMD_NUM) begin
          if (stack_fill < STACK_DEPTH) begin
            operand_stack[stack_fill] = {1'b0, operand};
            stack_fill++;
          end
        end else if (cmd <= CMD_DIV) begin
          if (stack_fill < 2) begin
            held_error = ST_FEW;
          end else begin
            top = operand_stack[stack_fill-1];
            nxt = operand_stack[stack_fill-2];
            stack_fill -= 2;
            acc = '0;
            case (cmd)
              CMD_ADD: acc = nxt + top;
              CMD_SUB: acc = nxt - top;
              CMD_MUL: acc = nxt * top;
              CMD_DIV: begin
                if (top == '0) held_error = ST_DIV0;
                else acc = trunc_divide(nxt, top);
              end
              default: acc = '0;
            endcase
            if (held_error == ST_OK) begin
              operand_stack[stack_fill] = acc;
              stack_fill++;
            end
          end
        end else begin
          held_error = ST_BAD;
        end
      end
      res.status = held_error;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    token_result_t want;
    if (!rst_n) begin
      stack_fill = 0;
      held_error = ST_OK;
      pending_results.delete();
      waiting = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(evaluate_token(in_tuser, in_tdata[30:0]));
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected: result_value %0d",
                 $signed(out_tdata));
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata !== want.value) begin
            $error("result_value: expected %0d, got %0d", $signed(want.value),
                   $signed(out_tdata));
            fail_count++;
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            fail_count++;
          end
          if (out_tlast !== want.closes) begin
            $error("done_res: expected %0b, got %0b", want.closes, out_tlast);
            fail_count++;
          end
        end
      end
      waiting = pending_results.size();
    end
  end

endmodule

FILE: sim/tb.sv
// Testbench top for postfix_stack_evaluator: clock, reset, token stimulus and result sink.
// Depends on psev_pkg, the evaluator RTL and postfix_stack_evaluator_checker.
module tb;
  import psev_pkg::*;

  localparam int TOKEN_GOAL = 550;
  localparam int LONG_HOLD  = 200;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  int          mismatches;
  int          outstanding;

  bit quiet = 1'b0;
  int hold_requests = 0;
  int tokens_sent = 0;

  postfix_stack_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  postfix_stack_evaluator_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(20 * 400000);
    $display("status: fail");
    $finish;
  end

  // Result sink: random stalls, long ready stretches, and a long hold-off on request.
  initial begin : result_sink
    int served;
    served = 0;
    out_tready <= 1'b0;
    forever begin
      if (served != hold_requests) begin
        served = hold_requests;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic logic [30:0] random_operand();
    case ($urandom_range(0, 5))
      0:       return 31'($urandom_range(0, 2));
      1, 2:    return 31'($urandom_range(0, 20));
      3:       return 31'h7FFF_FFFF;
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic logic [2:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return CMD_ADD;
      1:       return CMD_SUB;
      2:       return CMD_MUL;
      default: return CMD_DIV;
    endcase
  endfunction

  // Offers one token and returns right after the edge that accepts it; valid stays high.
  task automatic send_token(input logic [2:0] cmd, input logic [30:0] operand);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, operand};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tokens_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  // A well-formed expression with random operands and operators.
  task automatic send_expression();
    int operands;
    int pushed;
    int held;
    operands = $urandom_range(1, 7);
    pushed = 0;
    held = 0;
    while (pushed < operands || held > 1) begin
      if (pushed < operands && (held < 2 || $urandom_range(0, 1) == 1)) begin
        send_token(CMD_NUM, random_operand());
        pushed++;
        held++;
      end else begin
        send_token(random_operator(), 31'($urandom()));
        held--;
      end
    end
    send_token(CMD_END, 31'($urandom()));
  endtask

  // Random tokens of any kind, including invalid codes; mostly closed by an end token.
  task automatic send_noise();
    int count;
    count = $urandom_range(1, 8);
    repeat (count) send_token(3'($urandom_range(0, 7)), 31'($urandom()));
    if ($urandom_range(0, 3) != 0) send_token(CMD_END, 31'($urandom()));
  endtask

  initial begin : stimulus
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_NUM;
    rst_n     <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Most negative value divided by minus one.
    send_token(CMD_NUM, 31'h7FFF_FFFF);
    send_token(CMD_NUM, 31'd1);
    send_token(CMD_ADD, '0);
    send_token(CMD_NUM, 31'd0);
    send_token(CMD_NUM, 31'd1);
    send_token(CMD_SUB, '0);
    send_token(CMD_DIV, '0);
    send_token(CMD_END, '0);
    // Largest operands multiplied.
    send_token(CMD_NUM, 31'h7FFF_FFFF);
    send_token(CMD_NUM, 31'h7FFF_FFFF);
    send_token(CMD_MUL, 31'h7FFF_FFFF);
    send_token(CMD_END, 31'h7FFF_FFFF);
    // Divide by zero.
    send_token(CMD_NUM, 31'd5);
    send_token(CMD_NUM, 31'd0);
    send_token(CMD_DIV, '0);
    send_token(CMD_END, '0);
    // Operator with a single operand, then an end token after the error.
    send_token(CMD_NUM, 31'd9);
    send_token(CMD_SUB, '0);
    send_token(CMD_END, '0);
    // Invalid codes: 6 or 7 at random, then 7.
    send_token(3'($urandom_range(6, 7)) | 3'b110, '0);
    send_token(CMD_END, '0);
    send_token(3'b111, 31'h5555_5555);
    send_token(CMD_END, 31'h2AAA_AAAA);
    // End on an empty stack.
    send_token(CMD_END, '0);
    drain_results();

    // Overfill the stack while the sink holds off, so the input stalls and pushes drop.
    hold_requests++;
    repeat (STACK_DEPTH + 6) send_token(CMD_NUM, random_operand());
    repeat (STACK_DEPTH - 1) send_token(CMD_ADD, '0);
    send_token(CMD_END, '0);

    while (tokens_sent < TOKEN_GOAL) begin
      if (tokens_sent > TOKEN_GOAL - 80) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_expression();
      if (!quiet && $urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
